/* hw/rtl/wavr_pkg.sv */
// Shared types and constants for the RIFF/WAVE PCM stream reader.
// Holds the parse phase encoding, result codes, header identifiers and the result record.
// No dependencies.
package wavr_pkg;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_DATA   = 2'd1,
      PHASE_IDLE   = 2'd2
   } phase_type;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_NOT_RIFF = 3'd1;
   localparam logic [2:0] ERR_NOT_WAVE = 3'd2;
   localparam logic [2:0] ERR_NOT_FMT  = 3'd3;
   localparam logic [2:0] ERR_CHANNELS = 3'd4;

   // Identifiers stored with the first file byte in the lowest bits.
   localparam logic [31:0] ID_RIFF = 32'h4646_4952;
   localparam logic [31:0] ID_WAVE = 32'h4556_4157;
   localparam logic [31:0] ID_FMT  = 32'h2074_6D66;

   localparam logic [5:0] POS_LAST = 6'd43;

   localparam int RSP_DATA_W = 128;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [2:0]  error_code;
      logic [23:0] sample_value;
      logic        channel_side;
      logic        final_sample;
      logic [15:0] channel_count;
      logic [15:0] sample_bits;
      logic [31:0] rate_hz;
      logic [31:0] data_length;
   } result_type;

   function automatic logic [7:0] id_byte(input logic [31:0] id, input logic [1:0] k);
      logic [4:0] sh;
      sh = {k, 3'b000};
      return id[sh +: 8];
   endfunction

endpackage

/* hw/rtl/wavr_parse_core.sv */
// Header parser and sample assembler of the RIFF/WAVE PCM stream reader.
// Updates the parse state for each accepted request and gives the result it causes.
// Depends on wavr_pkg.
module wavr_parse_core
   import wavr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       data_byte,
   input  logic             new_file,
   output result_type       result
);

   phase_type   phase_ff, phase_in, phase_cur;
   logic [5:0]  pos_ff, pos_in, pos_cur;
   logic        mm_ff, mm_in, mm_cur;
   logic [15:0] chan_ff, chan_in, chan_cur;
   logic [15:0] bits_ff, bits_in, bits_cur;
   logic [31:0] rate_ff, rate_in, rate_cur;
   logic [31:0] left_ff, left_in, left_cur;
   logic [23:0] asm_ff, asm_in, asm_cur;
   logic [1:0]  bis_ff, bis_in, bis_cur;
   logic        side_ff, side_in, side_cur;

   logic        in_riff, in_wave, in_fmt, in_id;
   logic [31:0] id_word;
   logic        mm_next, id_fail, hdr_last, too_many;
   logic [2:0]  id_err;
   logic [15:0] chan_new, bits_new;
   logic [31:0] rate_new, len_new;

   logic [1:0]  bps;
   logic        stereo;
   logic [31:0] left_dec;
   logic [23:0] asm_new, sample;
   logic [1:0]  bis_inc;
   logic        done, emit, fin;
   logic [2:0]  frame_bytes;

   // A first byte of a file acts on freshly cleared state.
   assign phase_cur = new_file ? PHASE_HEADER : phase_ff;
   assign pos_cur   = new_file ? 6'd0  : pos_ff;
   assign mm_cur    = new_file ? 1'b0  : mm_ff;
   assign chan_cur  = new_file ? 16'd0 : chan_ff;
   assign bits_cur  = new_file ? 16'd0 : bits_ff;
   assign rate_cur  = new_file ? 32'd0 : rate_ff;
   assign left_cur  = new_file ? 32'd0 : left_ff;
   assign asm_cur   = new_file ? 24'd0 : asm_ff;
   assign bis_cur   = new_file ? 2'd0  : bis_ff;
   assign side_cur  = new_file ? 1'b0  : side_ff;

   // Header decode.
   assign in_riff = (pos_cur <= 6'd3);
   assign in_wave = (pos_cur >= 6'd8)  && (pos_cur <= 6'd11);
   assign in_fmt  = (pos_cur >= 6'd12) && (pos_cur <= 6'd15);
   assign in_id   = in_riff || in_wave || in_fmt;
   assign id_word = in_riff ? ID_RIFF : (in_wave ? ID_WAVE : ID_FMT);
   assign id_err  = in_riff ? ERR_NOT_RIFF : (in_wave ? ERR_NOT_WAVE : ERR_NOT_FMT);
   assign mm_next = ((pos_cur[1:0] == 2'd0) ? 1'b0 : mm_cur)
                    | (data_byte != id_byte(id_word, pos_cur[1:0]));
   assign id_fail = in_id && (pos_cur[1:0] == 2'd3) && mm_next;
   assign hdr_last = (pos_cur == POS_LAST);

   always_comb begin
      chan_new = chan_cur;
      bits_new = bits_cur;
      rate_new = rate_cur;
      len_new  = left_cur;
      unique case (pos_cur)
         6'd22: chan_new[7:0]   = data_byte;
         6'd23: chan_new[15:8]  = data_byte;
         6'd24: rate_new[7:0]   = data_byte;
         6'd25: rate_new[15:8]  = data_byte;
         6'd26: rate_new[23:16] = data_byte;
         6'd27: rate_new[31:24] = data_byte;
         6'd34: bits_new[7:0]   = data_byte;
         6'd35: bits_new[15:8]  = data_byte;
         6'd40: len_new[7:0]    = data_byte;
         6'd41: len_new[15:8]   = data_byte;
         6'd42: len_new[23:16]  = data_byte;
         6'd43: len_new[31:24]  = data_byte;
         default: ;
      endcase
   end

   assign too_many = (chan_new > 16'd2);

   // Data decode.
   assign bps = (bits_cur == 16'd16) ? 2'd2 : ((bits_cur == 16'd24) ? 2'd3 : 2'd0);
   assign stereo = (chan_cur == 16'd2);
   assign left_dec = left_cur - 32'd1;
   assign bis_inc = bis_cur + 2'd1;
   assign done = (bps != 2'd0) && (bis_inc >= bps);
   assign frame_bytes = stereo ? {bps, 1'b0} : {1'b0, bps};

   always_comb begin
      asm_new = asm_cur;
      unique case (bis_cur)
         2'd0: asm_new[7:0]   = asm_cur[7:0]   | data_byte;
         2'd1: asm_new[15:8]  = asm_cur[15:8]  | data_byte;
         2'd2: asm_new[23:16] = asm_cur[23:16] | data_byte;
         default: ;
      endcase
   end

   assign sample = (bps == 2'd2) ? {{8{asm_new[15]}}, asm_new[15:0]} : asm_new;
   assign emit = (stereo && !side_cur) ? (left_dec >= {30'd0, bps}) : 1'b1;
   assign fin  = (stereo && !side_cur) ? 1'b0 : (left_dec < {29'd0, frame_bytes});

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_cur)
            PHASE_HEADER: begin
               if (id_fail) begin
                  phase_in = PHASE_IDLE;
               end else if (hdr_last) begin
                  phase_in = (!too_many && (len_new != 32'd0)) ? PHASE_DATA : PHASE_IDLE;
               end else begin
                  phase_in = PHASE_HEADER;
               end
            end
            PHASE_DATA: phase_in = (left_dec == 32'd0) ? PHASE_IDLE : PHASE_DATA;
            default:    phase_in = PHASE_IDLE;
         endcase
      end
   end

   // Field updates and result.
   always_comb begin
      pos_in  = pos_ff;
      mm_in   = mm_ff;
      chan_in = chan_ff;
      bits_in = bits_ff;
      rate_in = rate_ff;
      left_in = left_ff;
      asm_in  = asm_ff;
      bis_in  = bis_ff;
      side_in = side_ff;
      result  = '0;
      if (take) begin
         pos_in  = pos_cur;
         mm_in   = mm_cur;
         chan_in = chan_cur;
         bits_in = bits_cur;
         rate_in = rate_cur;
         left_in = left_cur;
         asm_in  = asm_cur;
         bis_in  = bis_cur;
         side_in = side_cur;
         unique case (phase_cur)
            PHASE_HEADER: begin
               pos_in  = pos_cur + 6'd1;
               if (in_id) begin
                  mm_in = mm_next;
               end
               chan_in = chan_new;
               bits_in = bits_new;
               rate_in = rate_new;
               left_in = len_new;
               result.channel_count = chan_new;
               result.sample_bits   = bits_new;
               result.rate_hz       = rate_new;
               result.data_length   = len_new;
               if (id_fail) begin
                  result.valid      = 1'b1;
                  result.kind       = KIND_REJECT;
                  result.error_code = id_err;
               end else if (hdr_last) begin
                  result.valid      = 1'b1;
                  result.kind       = too_many ? KIND_REJECT : KIND_ACCEPT;
                  result.error_code = too_many ? ERR_CHANNELS : ERR_NONE;
               end
            end
            PHASE_DATA: begin
               left_in = left_dec;
               if (bps != 2'd0) begin
                  if (done) begin
                     asm_in  = 24'd0;
                     bis_in  = 2'd0;
                     side_in = stereo ? !side_cur : 1'b0;
                     result.valid        = emit;
                     result.kind         = KIND_SAMPLE;
                     result.sample_value = sample;
                     result.channel_side = side_cur;
                     result.final_sample = fin;
                  end else begin
                     asm_in = asm_new;
                     bis_in = bis_inc;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HEADER;
         pos_ff   <= '0;
         mm_ff    <= 1'b0;
         chan_ff  <= '0;
         bits_ff  <= '0;
         rate_ff  <= '0;
         left_ff  <= '0;
         asm_ff   <= '0;
         bis_ff   <= '0;
         side_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         mm_ff    <= mm_in;
         chan_ff  <= chan_in;
         bits_ff  <= bits_in;
         rate_ff  <= rate_in;
         left_ff  <= left_in;
         asm_ff   <= asm_in;
         bis_ff   <= bis_in;
         side_ff  <= side_in;
      end
   end

endmodule

/* hw/rtl/wav_pcm_stream_reader.sv */
// RIFF/WAVE PCM stream reader; a result shows in the cycle after its request is taken.
// Throughput one byte per cycle; each byte is decoded in the cycle it is taken and any
// result lands in a single output register, so requests stall while it is held unread.
// Reset (synchronous, active high) returns the parser to header byte 0 with all fields
// cleared and the output register empty. Top level; depends on wavr_pkg and wavr_parse_core.
module wav_pcm_stream_reader
   import wavr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // data_byte[7:0]
   input  logic [0:0]            req_tuser,  // new_file[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // error_code[2:0], sample_value[26:3], channel_side[27], channel_count[43:28],
   // sample_bits[59:44], rate_hz[91:60], data_length[123:92], zero[127:124]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,  // result_kind[1:0]
   output logic                  rsp_tlast   // final_sample
);

   result_type result;
   logic       take;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take = req_tvalid && req_tready;

   wavr_parse_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_tdata),
      .new_file  (req_tuser[0]),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = result.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.final_sample;
   assign rsp_tdata  = {4'd0, rsp_ff.data_length, rsp_ff.rate_hz, rsp_ff.sample_bits,
                        rsp_ff.channel_count, rsp_ff.channel_side, rsp_ff.sample_value,
                        rsp_ff.error_code};

   a_sample_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SAMPLE) |-> (rsp_tdata[2:0] == ERR_NONE))
      else $error("sample result carries an error code");

   a_header_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_SAMPLE) |-> !rsp_tlast)
      else $error("header result marked as final sample");

   a_reject_has_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_REJECT) |-> (rsp_tdata[2:0] != ERR_NONE))
      else $error("rejection without an error code");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_SAMPLE) || (rsp_tuser == KIND_ACCEPT)
                     || (rsp_tuser == KIND_REJECT))
      else $error("unknown result kind");

   a_held_when_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("pending result lost while stalled");

endmodule
